// ----- hdl/qnlerp_pkg.sv -----
// ============================================================================
// qnlerp_pkg
// Shared widths and item types of the quaternion normalized lerp unit.
// ============================================================================
package qnlerp_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int BLEND_BITS = 16;
    localparam int COMP_W     = 16;
    localparam int NUM_COMP   = 4;

    localparam int Q_W    = COMP_W + 1;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int S_W    = 2 * Q_W + 1;
    localparam int G_W    = S_W + ROOT_W + 1;
    localparam int ACC_W  = S_W + 2 * ROOT_W + 3;
    localparam int POS_W  = $clog2(ROOT_W);

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic [COMP_W-1:0]           blend_fraction;
        comp_t [NUM_COMP-1:0]        second_q;
        comp_t [NUM_COMP-1:0]        first_q;
    } in_item_t;

    typedef struct packed {
        logic                        neg;
        logic signed [ACC_W-1:0]     resid;
        logic [G_W-1:0]              g;
        logic [ROOT_W-1:0]           root;
    } lane_t;

    typedef struct packed {
        logic [S_W-1:0]              s;
        lane_t [NUM_COMP-1:0]        lane;
    } work_t;

endpackage

// ----- hdl/qnlerp_front.sv -----
// ============================================================================
// qnlerp_front
// Hemisphere alignment, per-component blend, rounding and squared norm.
// ============================================================================
module qnlerp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qnlerp_pkg::in_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qnlerp_pkg::work_t    out_work
);
    import qnlerp_pkg::*;

    localparam int NSTAGE = 7;
    localparam int P_W    = 2 * COMP_W;
    localparam int DOT_W  = P_W + 2;
    localparam int D_W    = COMP_W + 2;
    localparam int DT_W   = D_W + BLEND_BITS + 1;
    localparam int EXT_W  = DT_W + 2;
    localparam logic [31:0] T_MAX = (32'd1 << BLEND_BITS) - 32'd1;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] rdy;

    logic signed [P_W-1:0]        prod0_reg [NUM_COMP];
    logic signed [COMP_W-1:0]     a0_reg [NUM_COMP];
    logic signed [COMP_W-1:0]     b0_reg [NUM_COMP];
    logic [BLEND_BITS-1:0]        t0_reg;
    logic signed [DOT_W-1:0]      dot1_reg;
    logic signed [COMP_W-1:0]     a1_reg [NUM_COMP];
    logic signed [COMP_W-1:0]     b1_reg [NUM_COMP];
    logic [BLEND_BITS-1:0]        t1_reg;
    logic signed [D_W-1:0]        d2_reg [NUM_COMP];
    logic signed [COMP_W-1:0]     a2_reg [NUM_COMP];
    logic [BLEND_BITS-1:0]        t2_reg;
    logic signed [DT_W-1:0]       dt3_reg [NUM_COMP];
    logic signed [COMP_W-1:0]     a3_reg [NUM_COMP];
    logic signed [Q_W-1:0]        q4_reg [NUM_COMP];
    logic [2*Q_W-1:0]             sq5_reg [NUM_COMP];
    logic [NUM_COMP-1:0]          neg5_reg;
    work_t                        work_reg;

    logic signed [DOT_W-1:0]      dot_sum;
    logic signed [Q_W-1:0]        b_ext [NUM_COMP];
    logic signed [Q_W-1:0]        b_al [NUM_COMP];
    logic signed [EXT_W-1:0]      ext [NUM_COMP];
    logic [S_W-1:0]               s_sum;
    logic [BLEND_BITS-1:0]        t_sat;

    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTAGE-1];
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        t_sat = (32'(in_item.blend_fraction) > T_MAX) ? BLEND_BITS'(T_MAX)
                                                      : BLEND_BITS'(in_item.blend_fraction);
        dot_sum = '0;
        s_sum   = '0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            dot_sum = dot_sum + DOT_W'(prod0_reg[i]);
            b_ext[i] = Q_W'(b1_reg[i]);
            b_al[i]  = (dot1_reg < 0) ? -b_ext[i] : b_ext[i];
            ext[i]   = (EXT_W'(a3_reg[i]) <<< BLEND_BITS) + EXT_W'(dt3_reg[i])
                     + $signed(EXT_W'(1) << (BLEND_BITS - 1));
            s_sum    = s_sum + S_W'(sq5_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                a0_reg[i]    <= $signed(in_item.first_q[i]);
                b0_reg[i]    <= $signed(in_item.second_q[i]);
                prod0_reg[i] <= $signed(in_item.first_q[i]) * $signed(in_item.second_q[i]);
            end
            t0_reg <= t_sat;
        end
        if (rdy[1])
        begin
            dot1_reg <= dot_sum;
            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            t1_reg   <= t0_reg;
        end
        if (rdy[2])
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                d2_reg[i] <= D_W'(b_al[i]) - D_W'(a1_reg[i]);
            end
            a2_reg <= a1_reg;
            t2_reg <= t1_reg;
        end
        if (rdy[3])
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                dt3_reg[i] <= DT_W'(d2_reg[i]) * DT_W'($signed({1'b0, t2_reg}));
            end
            a3_reg <= a2_reg;
        end
        if (rdy[4])
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                q4_reg[i] <= Q_W'(ext[i] >>> BLEND_BITS);
            end
        end
        if (rdy[5])
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                sq5_reg[i]  <= $unsigned((2*Q_W)'(q4_reg[i]) * (2*Q_W)'(q4_reg[i]));
                neg5_reg[i] <= q4_reg[i][Q_W-1];
            end
        end
        if (rdy[6])
        begin
            work_reg.s <= s_sum;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                work_reg.lane[i].neg   <= neg5_reg[i];
                work_reg.lane[i].resid <= $signed(ACC_W'(sq5_reg[i]) << (2 * FRAC_BITS + 2));
                work_reg.lane[i].g     <= '0;
                work_reg.lane[i].root  <= '0;
            end
        end
    end

endmodule

// ----- hdl/qnlerp_cell.sv -----
// ============================================================================
// qnlerp_cell
// One result bit of the normalize step: trial bit, compare, residual update.
// ============================================================================
module qnlerp_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [qnlerp_pkg::POS_W-1:0]  bit_pos,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  qnlerp_pkg::work_t             up_work,
    output logic                          down_valid,
    input  logic                          down_ready,
    output qnlerp_pkg::work_t             down_work
);
    import qnlerp_pkg::*;

    logic  v_reg;
    work_t work_reg;
    work_t work_next;

    logic signed [ACC_W-1:0] s_acc;
    logic signed [ACC_W-1:0] g_acc [NUM_COMP];
    logic signed [ACC_W-1:0] trial [NUM_COMP];
    logic signed [ACC_W-1:0] step [NUM_COMP];

    assign up_ready   = !v_reg || down_ready;
    assign down_valid = v_reg;
    assign down_work  = work_reg;

    always_comb
    begin
        work_next = up_work;
        s_acc     = $signed(ACC_W'(up_work.s));
        for (int i = 0; i < NUM_COMP; i++)
        begin
            g_acc[i] = $signed(ACC_W'(up_work.lane[i].g));
            step[i]  = (g_acc[i] << (32'(bit_pos) + 2)) + (s_acc << (2 * 32'(bit_pos) + 2));
            trial[i] = step[i] + s_acc - (g_acc[i] << 1) - (s_acc << (32'(bit_pos) + 2));
            if (trial[i] <= up_work.lane[i].resid)
            begin
                work_next.lane[i].resid = up_work.lane[i].resid - step[i];
                work_next.lane[i].g     = up_work.lane[i].g
                                        + (G_W'(up_work.s) << (32'(bit_pos) + 1));
                work_next.lane[i].root  = up_work.lane[i].root | (ROOT_W'(1) << bit_pos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ----- hdl/quaternion_normalized_lerp_unit.sv -----
// ============================================================================
// quaternion_normalized_lerp_unit
// Normalized linear interpolation of two Q2.14 unit quaternions.
// ============================================================================
// Each input item carries two quaternions and a blend fraction on the slave
// channel; each output item carries the normalized blend and a valid flag.
// The block accepts one item per cycle while the output is not stalled and
// returns exactly one output item for each, in order. Seven front stages
// align, blend, round and form the squared norm. A row of fifteen cells then
// finds the normalized components one result bit per cell, and a final
// register presents the item. Every stage holds its own valid bit, so a
// stalled receiver only stops the stages that are full and empty stages still
// take new items. Reset clears all valid bits and the channels come up empty.
// A blend whose squared norm is zero gives zero components with the valid
// flag low.
// ============================================================================
module quaternion_normalized_lerp_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_qx, first_qy, first_qz, first_qw, second_qx, second_qy,
    // second_qz, second_qw, blend_fraction
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_qx, out_qy, out_qz, out_qw
    output logic [63:0]  m_axis_tdata,
    // pose_valid
    output logic [0:0]   m_axis_tuser
);
    import qnlerp_pkg::*;

    in_item_t in_item;
    logic     chain_valid [ROOT_W+1];
    logic     chain_ready [ROOT_W+1];
    work_t    chain_work  [ROOT_W+1];

    logic                         out_valid_reg;
    logic [NUM_COMP*COMP_W-1:0]   out_data_reg;
    logic                         out_pose_reg;
    logic [NUM_COMP*COMP_W-1:0]   out_data_next;
    logic                         out_pose_next;

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            in_item.first_q[i]  = s_axis_tdata[i*COMP_W +: COMP_W];
            in_item.second_q[i] = s_axis_tdata[(NUM_COMP+i)*COMP_W +: COMP_W];
        end
        in_item.blend_fraction = s_axis_tdata[2*NUM_COMP*COMP_W +: COMP_W];
    end

    qnlerp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_work  (chain_work[0])
    );

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_cell
        qnlerp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bit_pos    (POS_W'(ROOT_W - 1 - k)),
            .up_valid   (chain_valid[k]),
            .up_ready   (chain_ready[k]),
            .up_work    (chain_work[k]),
            .down_valid (chain_valid[k+1]),
            .down_ready (chain_ready[k+1]),
            .down_work  (chain_work[k+1])
        );
    end

    assign chain_ready[ROOT_W] = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_pose_next = (chain_work[ROOT_W].s != '0);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (!out_pose_next)
            begin
                out_data_next[i*COMP_W +: COMP_W] = '0;
            end
            else if (chain_work[ROOT_W].lane[i].neg)
            begin
                out_data_next[i*COMP_W +: COMP_W] =
                    -COMP_W'(chain_work[ROOT_W].lane[i].root);
            end
            else
            begin
                out_data_next[i*COMP_W +: COMP_W] = COMP_W'(chain_work[ROOT_W].lane[i].root);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (chain_ready[ROOT_W])
        begin
            out_valid_reg <= chain_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_ready[ROOT_W])
        begin
            out_data_reg <= out_data_next;
            out_pose_reg <= out_pose_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_pose_reg;

endmodule

// ----- hdl/qnlerp_checker.sv -----
// ============================================================================
// qnlerp_checker
// Port-level checks of the output channel of the lerp unit.
// ============================================================================
module qnlerp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("Output item present during reset.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("Stalled output item changed.");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("Degenerate pose with nonzero components.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
                       && $signed(m_axis_tdata[15:0]) >= -16'sd16384
                       && $signed(m_axis_tdata[63:48]) <= 16'sd16384
                       && $signed(m_axis_tdata[63:48]) >= -16'sd16384)
        else $error("Output component outside unit range.");

endmodule

bind quaternion_normalized_lerp_unit qnlerp_checker u_qnlerp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
